/* src/vhd_pkg.sv */
// ----------------------------------------------------------------------------
// vhd_pkg: shared definitions for the vector heading block
// Octant codes, fixed headings, CORDIC arctangent entries and pipeline types.
// ----------------------------------------------------------------------------
package vhd_pkg;

   localparam int COORD_WIDTH_DEF   = 16;
   localparam int CORDIC_STAGES_DEF = 18;
   localparam int GUARD_BITS        = 24;
   localparam int ANGLE_FRAC        = 16;
   localparam int TABLE_LEN         = 24;
   localparam int ANGLE_WIDTH       = 25;
   localparam int CODE_WIDTH        = 5;
   localparam int HEADING_WIDTH     = 9;
   localparam int DIST_WIDTH        = 6;

   localparam logic [CODE_WIDTH-1:0] CODE_ZERO     = 5'd0;
   localparam logic [CODE_WIDTH-1:0] CODE_OCT_1    = 5'd1;
   localparam logic [CODE_WIDTH-1:0] CODE_OCT_2    = 5'd2;
   localparam logic [CODE_WIDTH-1:0] CODE_OCT_3    = 5'd3;
   localparam logic [CODE_WIDTH-1:0] CODE_OCT_4    = 5'd4;
   localparam logic [CODE_WIDTH-1:0] CODE_OCT_5    = 5'd5;
   localparam logic [CODE_WIDTH-1:0] CODE_OCT_6    = 5'd6;
   localparam logic [CODE_WIDTH-1:0] CODE_OCT_7    = 5'd7;
   localparam logic [CODE_WIDTH-1:0] CODE_OCT_8    = 5'd8;
   localparam logic [CODE_WIDTH-1:0] CODE_AXIS_000 = 5'd9;
   localparam logic [CODE_WIDTH-1:0] CODE_AXIS_270 = 5'd10;
   localparam logic [CODE_WIDTH-1:0] CODE_AXIS_180 = 5'd11;
   localparam logic [CODE_WIDTH-1:0] CODE_AXIS_090 = 5'd12;
   localparam logic [CODE_WIDTH-1:0] CODE_DIAG_315 = 5'd13;
   localparam logic [CODE_WIDTH-1:0] CODE_DIAG_045 = 5'd14;
   localparam logic [CODE_WIDTH-1:0] CODE_DIAG_135 = 5'd15;
   localparam logic [CODE_WIDTH-1:0] CODE_DIAG_225 = 5'd16;

   localparam logic [HEADING_WIDTH-1:0] DEG_0   = 9'd0;
   localparam logic [HEADING_WIDTH-1:0] DEG_45  = 9'd45;
   localparam logic [HEADING_WIDTH-1:0] DEG_90  = 9'd90;
   localparam logic [HEADING_WIDTH-1:0] DEG_135 = 9'd135;
   localparam logic [HEADING_WIDTH-1:0] DEG_180 = 9'd180;
   localparam logic [HEADING_WIDTH-1:0] DEG_225 = 9'd225;
   localparam logic [HEADING_WIDTH-1:0] DEG_270 = 9'd270;
   localparam logic [HEADING_WIDTH-1:0] DEG_315 = 9'd315;

   localparam logic [DIST_WIDTH-1:0] DIST_MAX = 6'd44;

   // control that rides along the cell chain
   typedef struct packed {
      logic                  valid;
      logic [CODE_WIDTH-1:0] code;
   } cell_ctrl_type;

   // atan(2^-idx) in degrees, 16 fraction bits, rounded to nearest
   function automatic logic [ANGLE_WIDTH-1:0] atan_entry(input int idx);
      logic [ANGLE_WIDTH-1:0] val;
      case (idx)
         0:  val = 25'd2949120;
         1:  val = 25'd1740967;
         2:  val = 25'd919879;
         3:  val = 25'd466945;
         4:  val = 25'd234379;
         5:  val = 25'd117304;
         6:  val = 25'd58666;
         7:  val = 25'd29335;
         8:  val = 25'd14668;
         9:  val = 25'd7334;
         10: val = 25'd3667;
         11: val = 25'd1833;
         12: val = 25'd917;
         13: val = 25'd458;
         14: val = 25'd229;
         15: val = 25'd115;
         16: val = 25'd57;
         17: val = 25'd29;
         18: val = 25'd14;
         19: val = 25'd7;
         20: val = 25'd4;
         21: val = 25'd2;
         22: val = 25'd1;
         default: val = 25'd0;
      endcase
      return val;
   endfunction

   function automatic logic is_octant(input logic [CODE_WIDTH-1:0] code);
      return (code >= CODE_OCT_1) && (code <= CODE_OCT_8);
   endfunction

   // start of the span for an octant code, fixed heading otherwise
   function automatic logic [HEADING_WIDTH-1:0] base_heading(
      input logic [CODE_WIDTH-1:0] code);
      logic [HEADING_WIDTH-1:0] val;
      case (code)
         CODE_OCT_1:    val = DEG_0;
         CODE_OCT_2:    val = DEG_45;
         CODE_OCT_3:    val = DEG_90;
         CODE_OCT_4:    val = DEG_135;
         CODE_OCT_5:    val = DEG_180;
         CODE_OCT_6:    val = DEG_225;
         CODE_OCT_7:    val = DEG_270;
         CODE_OCT_8:    val = DEG_315;
         CODE_AXIS_000: val = DEG_0;
         CODE_AXIS_270: val = DEG_270;
         CODE_AXIS_180: val = DEG_180;
         CODE_AXIS_090: val = DEG_90;
         CODE_DIAG_315: val = DEG_315;
         CODE_DIAG_045: val = DEG_45;
         CODE_DIAG_135: val = DEG_135;
         CODE_DIAG_225: val = DEG_225;
         default:       val = DEG_0;
      endcase
      return val;
   endfunction

endpackage

/* src/vhd_sort.sv */
// ----------------------------------------------------------------------------
// vhd_sort: octant classifier
// Registers the octant code and the larger and smaller magnitude, scaled up
// to the CORDIC working format.
// ----------------------------------------------------------------------------
module vhd_sort #(
   parameter int COORD_WIDTH = 16,
   localparam int XW = COORD_WIDTH + vhd_pkg::GUARD_BITS + 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [COORD_WIDTH-1:0]      x_coord,
   input  logic [COORD_WIDTH-1:0]      y_coord,
   output vhd_pkg::cell_ctrl_type      ctrl_out,
   output logic signed [XW-1:0]        cx_out,
   output logic signed [XW-1:0]        cy_out
);
   import vhd_pkg::*;

   logic                   sx;
   logic                   sy;
   logic                   xz;
   logic                   yz;
   logic [COORD_WIDTH:0]   x_neg;
   logic [COORD_WIDTH:0]   y_neg;
   logic [COORD_WIDTH-1:0] a_mag;
   logic [COORD_WIDTH-1:0] b_mag;
   logic [COORD_WIDTH-1:0] big;
   logic [COORD_WIDTH-1:0] small_mag;
   logic [CODE_WIDTH-1:0]  code;

   cell_ctrl_type          ctrl_ff;
   cell_ctrl_type          ctrl_in;
   logic signed [XW-1:0]   cx_ff;
   logic signed [XW-1:0]   cx_in;
   logic signed [XW-1:0]   cy_ff;
   logic signed [XW-1:0]   cy_in;

   always_comb begin
      sx    = x_coord[COORD_WIDTH-1];
      sy    = y_coord[COORD_WIDTH-1];
      xz    = (x_coord == '0);
      yz    = (y_coord == '0);
      x_neg = -{sx, x_coord};
      y_neg = -{sy, y_coord};
      a_mag = sx ? x_neg[COORD_WIDTH-1:0] : x_coord;
      b_mag = sy ? y_neg[COORD_WIDTH-1:0] : y_coord;

      if (xz && yz) begin
         code = CODE_ZERO;
      end else if (yz) begin
         code = sx ? CODE_AXIS_180 : CODE_AXIS_000;
      end else if (xz) begin
         code = sy ? CODE_AXIS_090 : CODE_AXIS_270;
      end else if (a_mag == b_mag) begin
         if (!sx && !sy) begin
            code = CODE_DIAG_315;
         end else if (!sx) begin
            code = CODE_DIAG_045;
         end else if (sy) begin
            code = CODE_DIAG_135;
         end else begin
            code = CODE_DIAG_225;
         end
      end else if (!sx && sy) begin
         code = (a_mag > b_mag) ? CODE_OCT_1 : CODE_OCT_2;
      end else if (sx && sy) begin
         code = (a_mag < b_mag) ? CODE_OCT_3 : CODE_OCT_4;
      end else if (sx) begin
         code = (a_mag > b_mag) ? CODE_OCT_5 : CODE_OCT_6;
      end else begin
         code = (a_mag < b_mag) ? CODE_OCT_7 : CODE_OCT_8;
      end

      big       = (a_mag > b_mag) ? a_mag : b_mag;
      small_mag = (a_mag > b_mag) ? b_mag : a_mag;

      ctrl_in.valid = in_valid;
      ctrl_in.code  = code;
      cx_in = signed'({2'b00, big, {GUARD_BITS{1'b0}}});
      cy_in = signed'({2'b00, small_mag, {GUARD_BITS{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign cx_out   = cx_ff;
   assign cy_out   = cy_ff;

endmodule

/* src/vhd_cell.sv */
// ----------------------------------------------------------------------------
// vhd_cell: one vectoring CORDIC micro-rotation
// Rotates toward the x axis by atan(2^-STAGE_INDEX) and hands the result on.
// ----------------------------------------------------------------------------
module vhd_cell #(
   parameter int COORD_WIDTH = 16,
   parameter int STAGE_INDEX = 0,
   localparam int XW = COORD_WIDTH + vhd_pkg::GUARD_BITS + 2,
   localparam int ZW = vhd_pkg::ANGLE_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  vhd_pkg::cell_ctrl_type      ctrl_prev,
   input  logic signed [XW-1:0]        cx_prev,
   input  logic signed [XW-1:0]        cy_prev,
   input  logic signed [ZW-1:0]        z_prev,
   output vhd_pkg::cell_ctrl_type      ctrl_next,
   output logic signed [XW-1:0]        cx_next,
   output logic signed [XW-1:0]        cy_next,
   output logic signed [ZW-1:0]        z_next
);
   import vhd_pkg::*;

   localparam logic signed [ZW-1:0] StepAngle = signed'(atan_entry(STAGE_INDEX));

   logic signed [XW-1:0] dx;
   logic signed [XW-1:0] dy;

   cell_ctrl_type        ctrl_ff;
   logic signed [XW-1:0] cx_ff;
   logic signed [XW-1:0] cx_in;
   logic signed [XW-1:0] cy_ff;
   logic signed [XW-1:0] cy_in;
   logic signed [ZW-1:0] z_ff;
   logic signed [ZW-1:0] z_in;

   always_comb begin
      // arithmetic shifts round toward minus infinity
      dx = cy_prev >>> STAGE_INDEX;
      dy = cx_prev >>> STAGE_INDEX;
      if (!cy_prev[XW-1]) begin
         cx_in = cx_prev + dx;
         cy_in = cy_prev - dy;
         z_in  = z_prev + StepAngle;
      end else begin
         cx_in = cx_prev - dx;
         cy_in = cy_prev + dy;
         z_in  = z_prev - StepAngle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= ctrl_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         z_ff  <= z_in;
      end
   end

   assign ctrl_next = ctrl_ff;
   assign cx_next   = cx_ff;
   assign cy_next   = cy_ff;
   assign z_next    = z_ff;

endmodule

/* src/vhd_finish.sv */
// ----------------------------------------------------------------------------
// vhd_finish: heading assembly
// Turns the CORDIC angle into a whole-degree distance from the diagonal and
// forms the heading from the octant code.
// ----------------------------------------------------------------------------
module vhd_finish #(
   localparam int ZW = vhd_pkg::ANGLE_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  vhd_pkg::cell_ctrl_type                 ctrl_prev,
   input  logic signed [ZW-1:0]                   z_prev,
   output logic                                   out_valid,
   output logic [vhd_pkg::HEADING_WIDTH-1:0]      heading_deg,
   output logic [vhd_pkg::CODE_WIDTH-1:0]         octant_code
);
   import vhd_pkg::*;

   localparam logic signed [ZW:0] DiagAngle = signed'((ZW+1)'(45 << ANGLE_FRAC));

   logic signed [ZW:0]           dist_val;
   logic [ZW-ANGLE_FRAC:0]       dist_whole;
   logic [DIST_WIDTH-1:0]        dist_deg;
   logic [HEADING_WIDTH-1:0]     base;
   logic [HEADING_WIDTH-1:0]     dist_ext;

   logic                         valid_ff;
   logic [HEADING_WIDTH-1:0]     heading_ff;
   logic [HEADING_WIDTH-1:0]     heading_in;
   logic [CODE_WIDTH-1:0]        code_ff;

   always_comb begin
      dist_val   = DiagAngle - {z_prev[ZW-1], z_prev};
      dist_whole = dist_val[ZW:ANGLE_FRAC];
      // clamp so the heading stays inside its octant
      if (dist_val[ZW]) begin
         dist_deg = '0;
      end else if (dist_whole > (ZW-ANGLE_FRAC+1)'(DIST_MAX)) begin
         dist_deg = DIST_MAX;
      end else begin
         dist_deg = dist_whole[DIST_WIDTH-1:0];
      end
      dist_ext = HEADING_WIDTH'(dist_deg);
      base     = base_heading(ctrl_prev.code);
      if (!is_octant(ctrl_prev.code)) begin
         heading_in = base;
      end else if (ctrl_prev.code[0]) begin
         heading_in = base + DEG_45 - dist_ext;
      end else begin
         heading_in = base + dist_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= ctrl_prev.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         heading_ff <= heading_in;
         code_ff    <= ctrl_prev.code;
      end
   end

   assign out_valid   = valid_ff;
   assign heading_deg = heading_ff;
   assign octant_code = code_ff;

endmodule

/* src/vector_heading_degrees.sv */
// ----------------------------------------------------------------------------
// vector_heading_degrees: heading of a signed 2D vector in whole degrees
// Octant sort, a chain of CORDIC cells and a heading stage, with an output
// register and a skid register on the result side.
// ----------------------------------------------------------------------------
// Usage:
//   Send one vector per beat on req_ (x_coord, y_coord). Each beat gives one
//   result beat on rsp_ holding heading_deg (0..359, counted from +x toward
//   -y, screen axes) and octant_code (zero, octant, axis or diagonal).
//   From request to result a vector passes one sort stage, one cell per CORDIC
//   stage, one heading stage and one output register.
//   Throughput is one vector per cycle while req_tready is high; each cell takes
//   a new item and hands its partial rotation on whenever the chain advances.
//   When rsp_tready is low the waiting result holds in the output register
//   and the next finished one drops into the skid register; only then does
//   the chain hold and req_tready fall, until the receiver takes a beat.
//   Reset clears all valid flags; req_tready is high in the cycle after.
// ----------------------------------------------------------------------------
module vector_heading_degrees #(
   parameter int COORD_WIDTH   = vhd_pkg::COORD_WIDTH_DEF,
   parameter int CORDIC_STAGES = vhd_pkg::CORDIC_STAGES_DEF,
   localparam int ReqDataWidth = ((2 * COORD_WIDTH + 7) / 8) * 8,
   localparam int RspDataWidth =
      ((vhd_pkg::HEADING_WIDTH + vhd_pkg::CODE_WIDTH + 7) / 8) * 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // x_coord [COORD_WIDTH-1:0], y_coord [2*COORD_WIDTH-1:COORD_WIDTH], zero fill
   input  logic [ReqDataWidth-1:0] req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // heading_deg [8:0], octant_code [13:9], zero fill
   output logic [RspDataWidth-1:0] rsp_tdata
);
   import vhd_pkg::*;

   localparam int XW = COORD_WIDTH + GUARD_BITS + 2;
   localparam int ZW = ANGLE_WIDTH;
   localparam int PayWidth = HEADING_WIDTH + CODE_WIDTH;

   logic                      en;
   cell_ctrl_type             ctrl_pipe [0:CORDIC_STAGES];
   logic signed [XW-1:0]      cx_pipe   [0:CORDIC_STAGES];
   logic signed [XW-1:0]      cy_pipe   [0:CORDIC_STAGES];
   logic signed [ZW-1:0]      z_pipe    [0:CORDIC_STAGES];

   logic                      fin_valid;
   logic [HEADING_WIDTH-1:0]  fin_heading;
   logic [CODE_WIDTH-1:0]     fin_code;
   logic                      take;
   logic                      out_free;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [PayWidth-1:0]       rsp_data_ff;
   logic [PayWidth-1:0]       rsp_data_in;
   logic                      skid_full_ff;
   logic                      skid_full_in;
   logic [PayWidth-1:0]       skid_data_ff;
   logic [PayWidth-1:0]       skid_data_in;

   // the chain advances whenever the skid register has room
   assign en         = !skid_full_ff;
   assign req_tready = en;

   vhd_sort #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_sort (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .x_coord  (req_tdata[COORD_WIDTH-1:0]),
      .y_coord  (req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
      .ctrl_out (ctrl_pipe[0]),
      .cx_out   (cx_pipe[0]),
      .cy_out   (cy_pipe[0])
   );

   assign z_pipe[0] = '0;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      vhd_cell #(
         .COORD_WIDTH(COORD_WIDTH),
         .STAGE_INDEX(i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .ctrl_prev (ctrl_pipe[i]),
         .cx_prev   (cx_pipe[i]),
         .cy_prev   (cy_pipe[i]),
         .z_prev    (z_pipe[i]),
         .ctrl_next (ctrl_pipe[i+1]),
         .cx_next   (cx_pipe[i+1]),
         .cy_next   (cy_pipe[i+1]),
         .z_next    (z_pipe[i+1])
      );
   end

   vhd_finish u_finish (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .ctrl_prev   (ctrl_pipe[CORDIC_STAGES]),
      .z_prev      (z_pipe[CORDIC_STAGES]),
      .out_valid   (fin_valid),
      .heading_deg (fin_heading),
      .octant_code (fin_code)
   );

   always_comb begin
      take         = fin_valid && en;
      out_free     = !rsp_valid_ff || rsp_tready;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      skid_full_in = skid_full_ff;
      skid_data_in = skid_data_ff;
      if (out_free) begin
         if (skid_full_ff) begin
            // drain the skid beat first
            rsp_valid_in = 1'b1;
            rsp_data_in  = skid_data_ff;
            skid_full_in = 1'b0;
         end else begin
            rsp_valid_in = take;
            rsp_data_in  = {fin_code, fin_heading};
         end
      end else if (take) begin
         skid_full_in = 1'b1;
         skid_data_in = {fin_code, fin_heading};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RspDataWidth'(rsp_data_ff);

endmodule

/* tb/vector_heading_degrees_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_heading_degrees_tb: self-checking bench for the vector heading block
// Streams signed vectors into the block, predicts heading and octant code
// with an independent CORDIC model, and checks every result beat in order.
// Runs directed corner vectors, then random vectors under several idle and
// stall mixes, including a long receiver hold-off that backs up the pipe.
// ----------------------------------------------------------------------------

typedef struct {
   logic [15:0] x_coord;
   logic [15:0] y_coord;
   logic [8:0]  heading_deg;
   logic [4:0]  octant_code;
} heading_due_type;

class heading_scoreboard;
   localparam int STAGES    = vhd_pkg::CORDIC_STAGES_DEF;
   localparam int GUARD     = vhd_pkg::GUARD_BITS;
   localparam int FRAC      = vhd_pkg::ANGLE_FRAC;
   localparam int ATAN_LEN  = 24;
   localparam int SPAN_DEG  = 45;
   localparam int DIST_LAST = 44;

   // atan(2^-i) in degrees, 16 fraction bits
   localparam longint ATAN_Q16 [ATAN_LEN] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   heading_due_type headings_due[$];
   int              mismatches;

   function new();
      mismatches = 0;
   endfunction

   // atan(minor/major) in degrees * 2^16, major > minor > 0
   function longint vector_angle(longint major, longint minor);
      longint cx, cy, z, dx, dy;
      cx = major <<< GUARD;
      cy = minor <<< GUARD;
      z  = 0;
      for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (cy >= 0) begin
            cx = cx + dx;
            cy = cy - dy;
            z  = z + ATAN_Q16[i];
         end else begin
            cx = cx - dx;
            cy = cy + dy;
            z  = z - ATAN_Q16[i];
         end
      end
      return z;
   endfunction

   function heading_due_type heading_of(logic [15:0] xin, logic [15:0] yin);
      heading_due_type r;
      longint x, y, a, b, gap, dist_deg;
      int offset;
      x = longint'($signed(xin));
      y = longint'($signed(yin));
      a = (x < 0) ? -x : x;
      b = (y < 0) ? -y : y;
      r.x_coord = xin;
      r.y_coord = yin;
      if (x == 0 && y == 0) begin
         r.octant_code = vhd_pkg::CODE_ZERO;
         r.heading_deg = vhd_pkg::DEG_0;
      end else if (y == 0) begin
         r.octant_code = (x > 0) ? vhd_pkg::CODE_AXIS_000 : vhd_pkg::CODE_AXIS_180;
         r.heading_deg = (x > 0) ? vhd_pkg::DEG_0 : vhd_pkg::DEG_180;
      end else if (x == 0) begin
         r.octant_code = (y > 0) ? vhd_pkg::CODE_AXIS_270 : vhd_pkg::CODE_AXIS_090;
         r.heading_deg = (y > 0) ? vhd_pkg::DEG_270 : vhd_pkg::DEG_90;
      end else if (a == b) begin
         if (x > 0 && y > 0) begin
            r.octant_code = vhd_pkg::CODE_DIAG_315;
            r.heading_deg = vhd_pkg::DEG_315;
         end else if (x > 0) begin
            r.octant_code = vhd_pkg::CODE_DIAG_045;
            r.heading_deg = vhd_pkg::DEG_45;
         end else if (y < 0) begin
            r.octant_code = vhd_pkg::CODE_DIAG_135;
            r.heading_deg = vhd_pkg::DEG_135;
         end else begin
            r.octant_code = vhd_pkg::CODE_DIAG_225;
            r.heading_deg = vhd_pkg::DEG_225;
         end
      end else begin
         if (x > 0 && y < 0)
            r.octant_code = (a > b) ? vhd_pkg::CODE_OCT_1 : vhd_pkg::CODE_OCT_2;
         else if (x < 0 && y < 0)
            r.octant_code = (a < b) ? vhd_pkg::CODE_OCT_3 : vhd_pkg::CODE_OCT_4;
         else if (x < 0)
            r.octant_code = (a > b) ? vhd_pkg::CODE_OCT_5 : vhd_pkg::CODE_OCT_6;
         else
            r.octant_code = (a < b) ? vhd_pkg::CODE_OCT_7 : vhd_pkg::CODE_OCT_8;
         // distance to the diagonal, clamped into the octant span
         gap = (longint'(SPAN_DEG) <<< FRAC) -
               ((a > b) ? vector_angle(a, b) : vector_angle(b, a));
         if (gap < 0)
            gap = 0;
         dist_deg = gap >>> FRAC;
         if (dist_deg > DIST_LAST)
            dist_deg = DIST_LAST;
         offset = (int'(r.octant_code) - 1) * SPAN_DEG;
         if (r.octant_code[0])
            r.heading_deg = 9'(offset + SPAN_DEG - int'(dist_deg));
         else
            r.heading_deg = 9'(offset + int'(dist_deg));
      end
      return r;
   endfunction

   function void note_vector(logic [15:0] xin, logic [15:0] yin);
      headings_due.push_back(heading_of(xin, yin));
   endfunction

   function void check_result(logic [15:0] beat);
      heading_due_type e;
      if (headings_due.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result beat: heading %0d code %0d",
                     beat[8:0], beat[13:9]);
         return;
      end
      e = headings_due.pop_front();
      if (beat[8:0] !== e.heading_deg || beat[13:9] !== e.octant_code ||
          beat[15:14] !== 2'b00) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"mismatch x=%0d y=%0d: heading exp %0d got %0d, ",
                      "code exp %0d got %0d, fill %b"},
                     $signed(e.x_coord), $signed(e.y_coord), e.heading_deg,
                     beat[8:0], e.octant_code, beat[13:9], beat[15:14]);
      end
   endfunction

   function int pending();
      return headings_due.size();
   endfunction
endclass

module vector_heading_degrees_tb;
   localparam int LATENCY = vhd_pkg::CORDIC_STAGES_DEF + 3;
   localparam int PHASE_ITEMS = 170;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_ask       = 1'b0;
   int hold_left      = 0;

   heading_scoreboard board = new();

   vector_heading_degrees uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // note accepted vectors and check result beats
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         board.note_vector(req_tdata[15:0], req_tdata[31:16]);
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata);
   end

   // receiver: random stalls, or a counted hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_ask) begin
            hold_ask  = 1'b0;
            hold_left = 90;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   task automatic send_vector(input logic [15:0] x, input logic [15:0] y);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      while (board.pending() > 0)
         @(posedge clock);
   endtask

   function automatic logic [15:0] signed_near(int mag);
      int v;
      v = $urandom_range(mag);
      return $urandom_range(1) ? 16'(v) : 16'(-v);
   endfunction

   task automatic send_random_vector();
      logic [15:0] x, y;
      int pick, m;
      pick = $urandom_range(99);
      if (pick < 40) begin
         x = 16'($urandom);
         y = 16'($urandom);
      end else if (pick < 60) begin
         // small vectors hit zero, axes and diagonals often
         x = signed_near(6);
         y = signed_near(6);
      end else if (pick < 80) begin
         // close to a diagonal
         m = $urandom_range(32767, 1);
         x = $urandom_range(1) ? 16'(m) : 16'(-m);
         m = m + $urandom_range(6) - 3;
         if (m > 32767)
            m = 32767;
         y = $urandom_range(1) ? 16'(m) : 16'(-m);
      end else begin
         // close to an axis
         x = 16'($urandom);
         y = signed_near(3);
         if ($urandom_range(1)) begin
            x = y;
            y = 16'($urandom);
         end
      end
      send_vector(x, y);
   endtask

   initial begin
      logic [15:0] corner_x [] = '{
         16'sd0, 16'sd32767, -16'sd32768, 16'sd0, 16'sd0,
         16'sd1, 16'sd1, -16'sd1, -16'sd1, -16'sd32768, 16'sd32767,
         16'sd2, 16'sd1, -16'sd1, -16'sd2, -16'sd2, -16'sd1, 16'sd1, 16'sd2,
         16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, -16'sd5
      };
      logic [15:0] corner_y [] = '{
         16'sd0, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768,
         16'sd1, -16'sd1, -16'sd1, 16'sd1, -16'sd32768, -16'sd32768,
         -16'sd1, -16'sd2, -16'sd2, -16'sd1, 16'sd1, 16'sd2, 16'sd2, 16'sd1,
         -16'sd32766, -16'sd1, 16'sd32767, 16'sd1, -16'sd1, 16'sd12
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // corner vectors, no idling
      foreach (corner_x[i])
         send_vector(corner_x[i], corner_y[i]);

      // back up the pipe while the receiver holds off
      hold_ask = 1'b1;
      repeat (60)
         send_random_vector();
      req_tvalid <= 1'b0;
      wait_drained();
      @(posedge clock);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 63;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 63;
            end
            default: begin
               send_idle_pct  = 21;
               recv_stall_pct = 21;
            end
         endcase
         repeat (PHASE_ITEMS)
            send_random_vector();
         req_tvalid <= 1'b0;
         wait_drained();
         @(posedge clock);
      end

      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
